// ----- rtl/hse_pkg.sv -----
// Shared field widths and command codes of the Huffman symbol encoder.
`default_nettype none
package hse_pkg;
	localparam int CMD_W = 2;
	localparam int SYM_W = 8;
	localparam int CODE_FIELD_W = 32;
	localparam int LEN_FIELD_W = 6;
	localparam int BYTE_W = 8;
	localparam int TABLE_DEPTH = 256;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_t;
endpackage
`default_nettype wire

// ----- rtl/hse_item_if.sv -----
// Input channel carrying load, encode and flush words.
`default_nettype none
interface hse_item_if;
	logic valid;
	logic ready;
	logic [hse_pkg::CMD_W-1:0] command;
	logic [hse_pkg::SYM_W-1:0] symbol;
	logic [hse_pkg::CODE_FIELD_W-1:0] code_bits;
	logic [hse_pkg::LEN_FIELD_W-1:0] code_length;

	modport source (output valid, command, symbol, code_bits, code_length, input ready);
	modport sink (input valid, command, symbol, code_bits, code_length, output ready);
endinterface
`default_nettype wire

// ----- rtl/hse_byte_if.sv -----
// Output channel carrying packed bytes.
`default_nettype none
interface hse_byte_if;
	logic valid;
	logic ready;
	logic [hse_pkg::BYTE_W-1:0] out_byte;
	logic last_of_run;

	modport source (output valid, out_byte, last_of_run, input ready);
	modport sink (input valid, out_byte, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/hse_code_table.sv -----
// Code table memory with per-entry valid bits and registered read.
`default_nettype none
module hse_code_table #(
	parameter int CODE_W = 32,
	parameter int LEN_W = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [hse_pkg::SYM_W-1:0] wr_addr,
	input wire logic [hse_pkg::CODE_FIELD_W-1:0] wr_code_bits,
	input wire logic [hse_pkg::LEN_FIELD_W-1:0] wr_code_length,
	input wire logic rd_en,
	input wire logic [hse_pkg::SYM_W-1:0] rd_addr,
	output logic [CODE_W-1:0] rd_word,
	output logic [LEN_W-1:0] rd_len
);
	import hse_pkg::*;

	localparam int ENTRY_W = CODE_W + LEN_W;

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [ENTRY_W-1:0] entry_s1;
	logic entry_valid_s1;
	logic [LEN_W-1:0] len_clamped;
	logic [CODE_W-1:0] word_mask;

	always_comb begin
		if (wr_code_length > LEN_FIELD_W'(CODE_W)) begin
			len_clamped = LEN_W'(CODE_W);
		end else begin
			len_clamped = LEN_W'(wr_code_length);
		end
		if (len_clamped >= LEN_W'(CODE_W)) begin
			word_mask = '1;
		end else begin
			word_mask = (CODE_W'(1) << len_clamped) - CODE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_code_bits[CODE_W-1:0] & word_mask, len_clamped};
		end
		if (rd_en) begin
			entry_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			entry_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				entry_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	// Entries never loaded read as an empty code.
	assign rd_word = entry_valid_s1 ? entry_s1[ENTRY_W-1:LEN_W] : '0;
	assign rd_len = entry_valid_s1 ? entry_s1[LEN_W-1:0] : '0;
endmodule
`default_nettype wire

// ----- rtl/hse_packer.sv -----
// Bit buffer that appends code words and emits bytes through an output register.
`default_nettype none
module hse_packer #(
	parameter int CODE_W = 32,
	parameter int LEN_W = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire hse_pkg::cmd_t item_cmd,
	input wire logic [CODE_W-1:0] item_word,
	input wire logic [LEN_W-1:0] item_len,
	output logic item_take,
	output logic out_valid,
	output logic [hse_pkg::BYTE_W-1:0] out_byte,
	output logic out_last,
	input wire logic out_ready
);
	import hse_pkg::*;

	localparam int BUF_W = CODE_W + BYTE_W - 1;
	localparam int CNT_W = $clog2(BUF_W + 1);

	logic [BUF_W-1:0] buf_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic out_last_q;

	logic out_can_load;
	logic drained;
	logic absorb;
	logic flush_go;
	logic emit;
	logic [BUF_W-1:0] eff_buf;
	logic [CNT_W-1:0] eff_cnt;
	logic [CNT_W-1:0] rem_cnt;
	logic [BUF_W-1:0] rem_mask;

	always_comb begin
		out_can_load = !out_valid_q || out_ready;
		drained = cnt_q < CNT_W'(BYTE_W);
		absorb = item_valid && (item_cmd == CMD_ENCODE) && drained;
		flush_go = item_valid && (item_cmd == CMD_FLUSH) && drained
			&& ((cnt_q == '0) || out_can_load);
		item_take = absorb || flush_go;
		if (absorb) begin
			eff_buf = (buf_q << item_len) | BUF_W'(item_word);
			eff_cnt = cnt_q + CNT_W'(item_len);
		end else begin
			eff_buf = buf_q;
			eff_cnt = cnt_q;
		end
		emit = (eff_cnt >= CNT_W'(BYTE_W)) && out_can_load;
		rem_cnt = eff_cnt - CNT_W'(BYTE_W);
		rem_mask = (BUF_W'(1) << rem_cnt) - BUF_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (flush_go) begin
				buf_q <= '0;
				cnt_q <= '0;
			end else if (emit) begin
				buf_q <= eff_buf & rem_mask;
				cnt_q <= rem_cnt;
			end else begin
				buf_q <= eff_buf;
				cnt_q <= eff_cnt;
			end
			if ((flush_go && (cnt_q != '0)) || emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (flush_go && (cnt_q != '0)) begin
			out_byte_q <= BYTE_W'(buf_q);
			out_last_q <= 1'b1;
		end else if (emit) begin
			out_byte_q <= BYTE_W'(eff_buf >> rem_cnt);
			out_last_q <= rem_cnt < CNT_W'(BYTE_W);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;
endmodule
`default_nettype wire

// ----- rtl/huffman_symbol_encoder.sv -----
// Table-driven Huffman symbol encoder with a byte packer.
// The item channel takes one word per cycle while ready is high: a load
// writes one symbol's code and length into the 256-entry code table, an
// encode appends that symbol's code to the bit buffer, and a flush sends the
// remaining bits right-aligned. The result channel carries packed bytes,
// earliest bit first, with last_of_run set on the final byte a word causes.
// A word is accepted into a stage that reads the code table, and the packer
// then merges it into the bit buffer and sends its first byte into the output
// register, so the first byte passes both registers before it is valid.
// An encode word yields up to four bytes, one per cycle while the receiver is
// ready; the next word is merged in the cycle after its predecessor's last byte
// left the buffer, so the packer takes no new word while a full byte remains.
// Reset clears the bit buffer and all valid flags, the table's per-entry flags too.
// When the receiver stalls, the output byte holds and the packer keeps one
// word waiting, after which the item channel drops ready.
`default_nettype none
module huffman_symbol_encoder #(
	parameter int MAX_CODE_LEN = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	hse_item_if.sink item,
	hse_byte_if.source result
);
	import hse_pkg::*;

	localparam int CODE_W = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
	localparam int LEN_W = $clog2(CODE_W + 1);

	logic item_acc;
	logic take;
	logic valid_s1;
	cmd_t cmd_s1;
	logic [CODE_W-1:0] word_s1;
	logic [LEN_W-1:0] len_s1;
	logic is_load;
	logic is_work;

	always_comb begin
		item.ready = !valid_s1 || take;
		item_acc = item.valid && item.ready;
		is_load = item.command == CMD_LOAD;
		is_work = (item.command == CMD_ENCODE) || (item.command == CMD_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item_acc && is_work;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			cmd_s1 <= cmd_t'(item.command);
		end
	end

	hse_code_table #(
		.CODE_W(CODE_W),
		.LEN_W(LEN_W)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(item_acc && is_load),
		.wr_addr(item.symbol),
		.wr_code_bits(item.code_bits),
		.wr_code_length(item.code_length),
		.rd_en(item_acc),
		.rd_addr(item.symbol),
		.rd_word(word_s1),
		.rd_len(len_s1)
	);

	hse_packer #(
		.CODE_W(CODE_W),
		.LEN_W(LEN_W)
	) u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(valid_s1),
		.item_cmd(cmd_s1),
		.item_word(word_s1),
		.item_len(len_s1),
		.item_take(take),
		.out_valid(result.valid),
		.out_byte(result.out_byte),
		.out_last(result.last_of_run),
		.out_ready(result.ready)
	);
endmodule
`default_nettype wire

// ----- rtl/hse_checker.sv -----
// Port-level checks of the encoder's result channel, bound to the top level.
`default_nettype none
module hse_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [hse_pkg::BYTE_W-1:0] out_byte,
	input wire logic out_last
);
	import hse_pkg::*;

	// A stalled byte must hold its value and flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output word changed");

	// The output register is empty while reset is held.
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// A byte that does not end its run is followed at once by the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("run ended without a last byte");
endmodule

bind huffman_symbol_encoder hse_checker u_hse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_byte(result.out_byte),
	.out_last(result.last_of_run)
);
`default_nettype wire
